>>> rtl/key_press_classifier_macros.svh
// assertion macros for the key press classifier
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

// consequence must hold in the cycle after the antecedent
`define KPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("key_press_classifier assertion failed");

`define KPC_ASSERT_TWO(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error("key_press_classifier assertion failed");

`endif

>>> rtl/kpc_pkg.sv
package kpc_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CONFIRM_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int EVENT_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_DOUBLE_CLICK = 2'd2,
        REG_CONFIRM      = 2'd3
    } t_cfg_reg;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 3'd0,
        EV_MENU_SHORT  = 3'd1,
        EV_UP_SHORT    = 3'd2,
        EV_UP_DOUBLE   = 3'd3,
        EV_UP_LONG     = 3'd4,
        EV_DOWN_SHORT  = 3'd5,
        EV_DOWN_DOUBLE = 3'd6,
        EV_DOWN_LONG   = 3'd7
    } t_key_event;

    typedef enum logic [1:0] {
        PRESS_NONE   = 2'd0,
        PRESS_SHORT  = 2'd1,
        PRESS_DOUBLE = 2'd2,
        PRESS_LONG   = 2'd3
    } t_press;

    typedef struct packed {
        logic [CFG_W-1:0]     debounce_ms;
        logic [CFG_W-1:0]     long_press_ms;
        logic [CFG_W-1:0]     double_click_ms;
        logic [CONFIRM_W-1:0] confirm_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        debounce_ms:     16'd50,
        long_press_ms:   16'd1000,
        double_click_ms: 16'd300,
        confirm_ms:      8'd10
    };

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              menu_high;
        logic              down_high;
        logic              up_high;
    } t_poll;

endpackage

>>> rtl/key_press_classifier.sv
// Key press classifier for three active-low keys (menu, down, up). Each input beat is one
// poll: a millisecond timestamp and a group of raw samples per key; each poll gives exactly
// one output beat carrying key_event (0 none, 1 menu short, 2/3/4 up short/double/long,
// 5/6/7 down short/double/long). A poll is accepted every cycle when the output side keeps
// up; its result passes through the two-entry poll queue that follows the majority vote
// and then the output register after the per-key timing logic. When the output is
// stalled, the queue fills and then stalls the input. The user must write timing registers
// through the config port only while the block is idle; the block does not enforce this.
`include "key_press_classifier_macros.svh"

module key_press_classifier #(
    parameter int SAMPLES_PER_POLL = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kpc_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_menu_samples,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_down_samples,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_up_samples,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kpc_pkg::EVENT_W-1:0]   o_key_event
);
    import kpc_pkg::*;

    localparam int POLL_W = $bits(t_poll);

    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_poll front_poll;
    t_poll back_poll;

    kpc_front #(
        .SAMPLES_PER_POLL (SAMPLES_PER_POLL)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_ms       (i_now_ms),
        .i_menu_samples (i_menu_samples),
        .i_down_samples (i_down_samples),
        .i_up_samples   (i_up_samples),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_poll         (front_poll)
    );

    kpc_fifo #(
        .WIDTH (POLL_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_poll),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_poll),
        .o_empty (q_empty)
    );

    kpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_data    (back_poll),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_key_event (o_key_event)
    );

    // a poll entering an idle block comes out through the queue and the output register
    `KPC_ASSERT_TWO(a_idle_latency, i_clk, i_rst_n, i_in_valid && !o_in_stall && q_empty && (!o_out_valid || !i_out_stall), o_out_valid)
    // a popped poll always lands in the output register
    `KPC_ASSERT_NEXT(a_pop_fills_out, i_clk, i_rst_n, q_pop, o_out_valid)
    // nothing queued and result taken leaves the output empty
    `KPC_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, o_out_valid && !i_out_stall && q_empty, !o_out_valid)

endmodule

>>> rtl/kpc_front.sv
module kpc_front #(
    parameter int SAMPLES_PER_POLL = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kpc_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_menu_samples,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_down_samples,
    input  logic [kpc_pkg::SAMPLE_W-1:0]  i_up_samples,
    input  logic                          i_q_full,
    output logic                          o_push,
    output kpc_pkg::t_poll                o_poll
);
    import kpc_pkg::*;

    localparam int VOTE_BITS = (SAMPLES_PER_POLL < SAMPLE_W) ? SAMPLES_PER_POLL : SAMPLE_W;
    localparam int CNT_W     = $clog2(SAMPLES_PER_POLL + 1);
    localparam int HALF      = SAMPLES_PER_POLL / 2;

    function automatic logic reads_high(input logic [SAMPLE_W-1:0] samples);
        logic [CNT_W-1:0] count;
        count = '0;
        for (int i = 0; i < VOTE_BITS; i++) begin
            count = count + CNT_W'(samples[i]);
        end
        return count > CNT_W'(HALF);
    endfunction

    logic r_seen_beat;

    // marks that at least one beat went by since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_beat <= 1'b0;
        end else if (o_push) begin
            r_seen_beat <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (r_seen_beat || !r_seen_beat);

    always_comb begin
        o_poll.now_ms    = i_now_ms;
        o_poll.menu_high = reads_high(i_menu_samples);
        o_poll.down_high = reads_high(i_down_samples);
        o_poll.up_high   = reads_high(i_up_samples);
    end

endmodule

>>> rtl/kpc_fifo.sv
module kpc_fifo #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

>>> rtl/kpc_key.sv
module kpc_key (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_high,
    input  logic [kpc_pkg::TIME_W-1:0] i_now,
    input  kpc_pkg::t_cfg              i_cfg,
    output kpc_pkg::t_press            o_press
);
    import kpc_pkg::*;

    logic              r_held;
    logic              r_long_done;
    logic              r_awaiting;
    logic [TIME_W-1:0] r_press_stamp;
    logic [TIME_W-1:0] r_release_stamp;
    logic [TIME_W-1:0] r_first_low;

    logic              n_held;
    logic              n_long_done;
    logic              n_awaiting;
    logic [TIME_W-1:0] n_press_stamp;
    logic [TIME_W-1:0] n_release_stamp;
    logic [TIME_W-1:0] n_first_low;

    logic [TIME_W-1:0] held_for;
    logic [TIME_W-1:0] low_for;
    logic [TIME_W-1:0] since_release;

    assign held_for = i_now - r_press_stamp;
    assign low_for  = i_now - r_first_low;

    always_comb begin
        n_held          = r_held;
        n_long_done     = r_long_done;
        n_awaiting      = r_awaiting;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_first_low     = r_first_low;
        o_press         = PRESS_NONE;

        if (!i_high && !r_held) begin
            if (r_awaiting) begin
                // second press inside the window
                n_awaiting    = 1'b0;
                n_held        = 1'b1;
                n_press_stamp = i_now;
                n_long_done   = 1'b0;
                o_press       = PRESS_DOUBLE;
            end else if (r_first_low == '0) begin
                n_first_low = i_now;
            end else if (low_for >= TIME_W'(i_cfg.confirm_ms)) begin
                n_held        = 1'b1;
                n_press_stamp = i_now;
                n_long_done   = 1'b0;
                n_first_low   = '0;
            end
        end else if (i_high) begin
            n_first_low = '0;
            if (r_held) begin
                n_held = 1'b0;
                if (held_for > TIME_W'(i_cfg.debounce_ms) && !r_long_done) begin
                    n_awaiting      = 1'b1;
                    n_release_stamp = i_now;
                end
            end
        end else if (!r_long_done) begin
            if (held_for > TIME_W'(i_cfg.long_press_ms)) begin
                n_long_done = 1'b1;
                o_press     = PRESS_LONG;
            end
        end

        // double click window expired
        since_release = i_now - n_release_stamp;
        if (n_awaiting && since_release > TIME_W'(i_cfg.double_click_ms)) begin
            n_awaiting = 1'b0;
            o_press    = PRESS_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held          <= 1'b0;
            r_long_done     <= 1'b0;
            r_awaiting      <= 1'b0;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_first_low     <= '0;
        end else if (i_en) begin
            r_held          <= n_held;
            r_long_done     <= n_long_done;
            r_awaiting      <= n_awaiting;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
            r_first_low     <= n_first_low;
        end
    end

endmodule

>>> rtl/kpc_back.sv
module kpc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_q_empty,
    input  kpc_pkg::t_poll                i_q_data,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kpc_pkg::EVENT_W-1:0]   o_key_event
);
    import kpc_pkg::*;

    t_cfg              r_cfg;
    logic              r_menu_held;
    logic [TIME_W-1:0] r_menu_stamp;
    logic              r_out_valid;
    t_key_event        r_key_event;

    logic              n_menu_held;
    logic [TIME_W-1:0] n_menu_stamp;

    logic [TIME_W-1:0] menu_held_for;
    t_key_event        menu_ev;
    t_key_event        result;
    t_press            down_press;
    t_press            up_press;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_DEBOUNCE:     r_cfg.debounce_ms     <= i_cfg_data;
                REG_LONG_PRESS:   r_cfg.long_press_ms   <= i_cfg_data;
                REG_DOUBLE_CLICK: r_cfg.double_click_ms <= i_cfg_data;
                REG_CONFIRM:      r_cfg.confirm_ms      <= i_cfg_data[CONFIRM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    // menu key
    assign menu_held_for = i_q_data.now_ms - r_menu_stamp;

    always_comb begin
        n_menu_held  = r_menu_held;
        n_menu_stamp = r_menu_stamp;
        menu_ev      = EV_NONE;
        if (!i_q_data.menu_high && !r_menu_held) begin
            n_menu_held  = 1'b1;
            n_menu_stamp = i_q_data.now_ms;
        end else if (i_q_data.menu_high && r_menu_held) begin
            n_menu_held = 1'b0;
            if (menu_held_for > TIME_W'(r_cfg.debounce_ms) &&
                menu_held_for < TIME_W'(r_cfg.long_press_ms)) begin
                menu_ev = EV_MENU_SHORT;
            end
        end
    end

    kpc_key u_down (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (o_pop),
        .i_high  (i_q_data.down_high),
        .i_now   (i_q_data.now_ms),
        .i_cfg   (r_cfg),
        .o_press (down_press)
    );

    kpc_key u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (o_pop),
        .i_high  (i_q_data.up_high),
        .i_now   (i_q_data.now_ms),
        .i_cfg   (r_cfg),
        .o_press (up_press)
    );

    // later keys override earlier ones: menu, down, up
    always_comb begin
        result = menu_ev;
        unique case (down_press)
            PRESS_SHORT:  result = EV_DOWN_SHORT;
            PRESS_DOUBLE: result = EV_DOWN_DOUBLE;
            PRESS_LONG:   result = EV_DOWN_LONG;
            default: ;
        endcase
        unique case (up_press)
            PRESS_SHORT:  result = EV_UP_SHORT;
            PRESS_DOUBLE: result = EV_UP_DOUBLE;
            PRESS_LONG:   result = EV_UP_LONG;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu_held  <= 1'b0;
            r_menu_stamp <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_menu_held  <= n_menu_held;
                r_menu_stamp <= n_menu_stamp;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_key_event <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_event = r_key_event;

endmodule

>>> sim/key_press_classifier_tb.sv
`timescale 1ns / 1ps

module key_press_classifier_tb;
    import kpc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int VOTES          = 8;
    localparam int MAX_WAIT       = 19;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDX_DOWN       = 0;
    localparam int IDX_UP         = 1;
    localparam logic [SAMPLE_W-1:0] PIN_HIGH = '1;
    localparam logic [SAMPLE_W-1:0] PIN_LOW  = '0;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [TIME_W-1:0]    i_now_ms       = '0;
    logic [SAMPLE_W-1:0]  i_menu_samples = '1;
    logic [SAMPLE_W-1:0]  i_down_samples = '1;
    logic [SAMPLE_W-1:0]  i_up_samples   = '1;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [EVENT_W-1:0]   o_key_event;

    key_press_classifier #(
        .SAMPLES_PER_POLL(VOTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_ms       (i_now_ms),
        .i_menu_samples (i_menu_samples),
        .i_down_samples (i_down_samples),
        .i_up_samples   (i_up_samples),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_key_event    (o_key_event)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // classifier state as the block should hold it
    t_cfg              cfg_model = CFG_RESET;
    logic              menu_held = 1'b0;
    logic [TIME_W-1:0] menu_press_at = '0;
    logic              key_held [2] = '{default: 1'b0};
    logic              long_fired [2] = '{default: 1'b0};
    logic              await_second [2] = '{default: 1'b0};
    logic [TIME_W-1:0] press_at [2] = '{default: '0};
    logic [TIME_W-1:0] release_at [2] = '{default: '0};
    logic [TIME_W-1:0] first_low_at [2] = '{default: '0};

    t_key_event pending_events [$];
    t_key_event expected_event;
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    bit         quiet_mode = 1'b0;

    function automatic logic pin_high(input logic [SAMPLE_W-1:0] samples);
        return $countones(samples) > VOTES / 2;
    endfunction

    function automatic logic [SAMPLE_W-1:0] vote_byte(input logic high);
        logic [SAMPLE_W-1:0] v;
        do v = SAMPLE_W'($urandom); while (pin_high(v) != high);
        return v;
    endfunction

    function automatic t_key_event step_key(input int k, input logic high,
                                            input logic [TIME_W-1:0] now,
                                            input t_key_event ev_short,
                                            input t_key_event ev_double,
                                            input t_key_event ev_long);
        t_key_event ev;
        ev = EV_NONE;
        if (!high && !key_held[k]) begin
            if (await_second[k]) begin
                await_second[k] = 1'b0;
                key_held[k]     = 1'b1;
                press_at[k]     = now;
                long_fired[k]   = 1'b0;
                ev              = ev_double;
            end else if (first_low_at[k] == '0) begin
                first_low_at[k] = now;
            end else if (TIME_W'(now - first_low_at[k]) >= cfg_model.confirm_ms) begin
                key_held[k]     = 1'b1;
                press_at[k]     = now;
                long_fired[k]   = 1'b0;
                first_low_at[k] = '0;
            end
        end else if (high) begin
            first_low_at[k] = '0;
            if (key_held[k]) begin
                key_held[k] = 1'b0;
                if (TIME_W'(now - press_at[k]) > cfg_model.debounce_ms && !long_fired[k]) begin
                    await_second[k] = 1'b1;
                    release_at[k]   = now;
                end
            end
        end else if (!long_fired[k]) begin
            if (TIME_W'(now - press_at[k]) > cfg_model.long_press_ms) begin
                long_fired[k] = 1'b1;
                ev            = ev_long;
            end
        end
        if (await_second[k] && TIME_W'(now - release_at[k]) > cfg_model.double_click_ms) begin
            await_second[k] = 1'b0;
            ev              = ev_short;
        end
        return ev;
    endfunction

    function automatic t_key_event classify_poll(input logic [TIME_W-1:0] now,
                                                 input logic [SAMPLE_W-1:0] menu_s,
                                                 input logic [SAMPLE_W-1:0] down_s,
                                                 input logic [SAMPLE_W-1:0] up_s);
        t_key_event        result;
        t_key_event        ev;
        logic [TIME_W-1:0] held_for;
        logic              menu_hi;
        result  = EV_NONE;
        menu_hi = pin_high(menu_s);
        if (!menu_hi && !menu_held) begin
            menu_held     = 1'b1;
            menu_press_at = now;
        end else if (menu_hi && menu_held) begin
            held_for  = now - menu_press_at;
            menu_held = 1'b0;
            if (held_for > cfg_model.debounce_ms && held_for < cfg_model.long_press_ms)
                result = EV_MENU_SHORT;
        end
        ev = step_key(IDX_DOWN, pin_high(down_s), now, EV_DOWN_SHORT, EV_DOWN_DOUBLE,
                      EV_DOWN_LONG);
        if (ev != EV_NONE)
            result = ev;
        ev = step_key(IDX_UP, pin_high(up_s), now, EV_UP_SHORT, EV_UP_DOUBLE, EV_UP_LONG);
        if (ev != EV_NONE)
            result = ev;
        return result;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_poll(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] menu_s,
                             input logic [SAMPLE_W-1:0] down_s,
                             input logic [SAMPLE_W-1:0] up_s);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_now_ms       <= now;
        i_menu_samples <= menu_s;
        i_down_samples <= down_s;
        i_up_samples   <= up_s;
        do @(posedge i_clk); while (o_in_stall);
        pending_events.push_back(classify_poll(now, menu_s, down_s, up_s));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE:     cfg_model.debounce_ms     = data;
            REG_LONG_PRESS:   cfg_model.long_press_ms   = data;
            REG_DOUBLE_CLICK: cfg_model.double_click_ms = data;
            REG_CONFIRM:      cfg_model.confirm_ms      = data[CONFIRM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] debounce,
                                  input logic [CFG_W-1:0] long_press,
                                  input logic [CFG_W-1:0] double_click,
                                  input logic [CFG_W-1:0] confirm);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_LONG_PRESS, long_press);
        write_reg(REG_DOUBLE_CLICK, double_click);
        write_reg(REG_CONFIRM, confirm);
    endtask

    // keys toggle at random over a walking timestamp, with some garbage polls mixed in
    task automatic run_traffic(input int count, input int max_step);
        logic [TIME_W-1:0] now;
        logic              menu_hi;
        logic              down_hi;
        logic              up_hi;
        now     = $urandom;
        menu_hi = 1'b1;
        down_hi = 1'b1;
        up_hi   = 1'b1;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 2)
                quiet_mode = !quiet_mode;
            if ($urandom_range(0, 19) == 0) begin
                send_poll($urandom, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          SAMPLE_W'($urandom));
            end else begin
                now += $urandom_range(0, max_step);
                if ($urandom_range(0, 3) == 0) menu_hi = !menu_hi;
                if ($urandom_range(0, 3) == 0) down_hi = !down_hi;
                if ($urandom_range(0, 3) == 0) up_hi = !up_hi;
                send_poll(now, vote_byte(menu_hi), vote_byte(down_hi), vote_byte(up_hi));
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_menu_short();
        send_poll(100, PIN_LOW, PIN_HIGH, PIN_HIGH);
        send_poll(200, PIN_HIGH, PIN_HIGH, PIN_HIGH);
        send_poll(300, PIN_LOW, PIN_HIGH, PIN_HIGH);
        send_poll(320, PIN_HIGH, PIN_HIGH, PIN_HIGH);
    endtask

    // includes a first low at time zero, which does not start confirmation
    task automatic test_up_double_long();
        send_poll(0, PIN_HIGH, PIN_HIGH, PIN_LOW);
        send_poll(5, PIN_HIGH, PIN_HIGH, PIN_LOW);
        send_poll(15, PIN_HIGH, PIN_HIGH, PIN_LOW);
        send_poll(100, PIN_HIGH, PIN_HIGH, PIN_HIGH);
        send_poll(200, PIN_HIGH, PIN_HIGH, PIN_LOW);
        send_poll(1300, PIN_HIGH, PIN_HIGH, PIN_LOW);
        send_poll(1400, PIN_HIGH, PIN_HIGH, PIN_HIGH);
        send_poll(1500, PIN_HIGH, PIN_HIGH, PIN_HIGH);
    endtask

    // both keys time out in the same poll, up has to win
    task automatic test_short_priority();
        send_poll(2000, PIN_HIGH, PIN_LOW, PIN_LOW);
        send_poll(2010, PIN_HIGH, PIN_LOW, PIN_LOW);
        send_poll(2100, PIN_HIGH, PIN_HIGH, PIN_HIGH);
        send_poll(2500, PIN_HIGH, PIN_HIGH, PIN_HIGH);
    endtask

    task automatic test_vote_threshold();
        send_poll(3000, 8'h1F, 8'h0F, 8'hFF);
        send_poll(3020, 8'hF8, 8'hF0, 8'hFF);
        send_poll(3100, 8'h1F, 8'hE0, 8'h87);
    endtask

    task automatic test_time_wrap();
        send_poll(32'hFFFF_FFF0, PIN_LOW, PIN_HIGH, PIN_HIGH);
        send_poll(32'h0000_0040, PIN_HIGH, PIN_HIGH, PIN_HIGH);
        send_poll(32'h0000_0010, PIN_HIGH, PIN_LOW, PIN_HIGH);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] l;
        logic [CFG_W-1:0] w;
        int               span;
        run_traffic(300, 300);
        apply_settings('0, '0, '0, '0);
        run_traffic(250, 3);
        apply_settings('1, '1, '1, '1);
        run_traffic(250, 16384);
        repeat (3) begin
            d    = CFG_W'($urandom) >> $urandom_range(0, 12);
            l    = CFG_W'($urandom) >> $urandom_range(0, 12);
            w    = CFG_W'($urandom) >> $urandom_range(0, 12);
            span = (d > l) ? d : l;
            span = (w > span) ? w : span;
            apply_settings(d, l, w, CFG_W'($urandom));
            run_traffic(180, span / 4 + 2);
        end
        apply_settings(16'd20, 16'd200, 16'd60, 16'd3);
        run_traffic(60, 60);
        wait_idle();
        run_traffic(60, 60);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, key_event %0d", o_key_event));
                end else begin
                    expected_event = pending_events.pop_front();
                    if (o_key_event !== expected_event)
                        report_mismatch($sformatf("key_event %0d, expected %s",
                                                  o_key_event, expected_event.name()));
                end
                stall_left = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_menu_short();
        test_up_double_long();
        test_short_priority();
        test_vote_threshold();
        test_time_wrap();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
